@@ sv/cgem_pkg.sv @@
// Shared types and constants of the compass gradient edge map block.
`default_nettype none

package cgem_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int GRAD_W     = 11;  // signed six-tap difference, +/-765
    localparam int MAG_W      = 10;  // magnitude of a difference, up to 765
    localparam int SUM_W      = 12;  // nine-pixel sum, up to 2295
    localparam int SCALED_W   = 14;  // twelve times a magnitude, up to 9180
    localparam int FIFO_DEPTH = 4;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 9'd160;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 9'd120;
    localparam logic [7:0]       RST_EDGE_THRESHOLD = 8'd0;
    localparam logic             RST_AUTO_MODE      = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE      = 4'd3;

    typedef logic [PIX_W-1:0] pixel_t;

    // 3x3 neighbourhood, index = row * 3 + column
    typedef pixel_t [8:0] win_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } meta_t;

    typedef struct packed {
        logic               edge_bit;
        logic [COORD_W-1:0] col_index;
        logic [COORD_W-1:0] row_index;
        logic               frame_done;
    } result_t;

endpackage

`default_nettype wire

@@ sv/compass_gradient_edge_map_unit.sv @@
// Top level of the compass gradient edge map: line stores, window, counters and result queue.
//
// Usage: gray pixels enter in raster order on the s_ request channel (s_valid, s_ready,
// s_gray_pixel). Each pixel at row r >= 2 and column c >= 2 completes the 3x3 window
// centred on (r-1, c-1) and gives one request on the m_ channel: edge flag, centre
// column, centre row and a frame-done mark on the last interior pixel. Border pixels
// give nothing on m_.
// Configuration (frame size, threshold, auto mode) is written through cfg_we, cfg_index
// and cfg_wdata while the block is idle; a write takes effect at once.
// A result passes stage 1, the gradient register and the result queue before it shows on m_valid.
// Throughput: one pixel per cycle while s_ready is high, set by the line-store read-modify-write
// (read the column at acceptance, write it back in the next cycle).
// When the receiver stalls, results wait in a four-entry queue; s_ready stays high as
// long as the queue plus the results still in the pipeline leave a free entry, so the
// input side keeps flowing until the queue fills up and then holds.
// Reset (aresetn low, synchronous) restores the register defaults, clears the window
// and the position counters and empties the queue. The line stores are not cleared;
// every entry is rewritten with pixel data before an interior result uses it.
`default_nettype none

module compass_gradient_edge_map_unit
    import cgem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // pixel request channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [PIX_W-1:0]     s_gray_pixel,
    // result request channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_edge_bit,
    output logic [COORD_W-1:0]        m_col_index,
    output logic [COORD_W-1:0]        m_row_index,
    output logic                      m_frame_done,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int NW = PW + 1;

    // configuration
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [7:0]       edge_threshold_reg;
    logic             auto_mode_reg;

    // position of the next pixel
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          at_row_end;
    logic          at_last_row;
    logic          s_acc;

    // stage 1: line-store data arrives
    logic          v1_reg;
    logic          emit1_reg;
    pixel_t        p1_reg;
    logic [CW-1:0] c1_reg;
    meta_t         meta1_reg;
    meta_t         meta_next;
    pixel_t        upper_rdata;
    pixel_t        middle_rdata;
    pixel_t        win_reg [6];
    win_t          win;

    // gradient stage and result queue
    logic          res_valid;
    result_t       res;
    result_t       fifo_mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] fifo_cnt_reg;
    logic [NW-1:0] pending;
    logic          push;
    logic          pop;

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            edge_threshold_reg <= RST_EDGE_THRESHOLD;
            auto_mode_reg      <= RST_AUTO_MODE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata;
                CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata;
                CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_wdata[7:0];
                CFG_AUTO_MODE:      auto_mode_reg      <= cfg_wdata[0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Saturate the frame size to 3..MAX and keep only its last index.
    always_comb begin
        if (frame_width_reg < 9'd3) begin
            last_col = CW'(2);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(frame_width_reg - 9'd1);
        end
        if (frame_height_reg < 9'd3) begin
            last_row = RW'(2);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row = RW'(frame_height_reg - 9'd1);
        end
    end

    // ---------------------------------------------------------------- acceptance
    // Credit check: queue entries plus results still in flight must leave room.
    assign pending = fifo_cnt_reg + NW'(v1_reg & emit1_reg) + NW'(res_valid);
    assign s_ready = pending < NW'(FIFO_DEPTH);
    assign s_acc   = s_valid & s_ready;

    assign at_row_end  = col_cnt_reg >= last_col;
    assign at_last_row = row_cnt_reg >= last_row;

    always_comb begin
        if (at_row_end) begin
            col_cnt_next = '0;
            row_cnt_next = at_last_row ? '0 : row_cnt_reg + RW'(1);
        end else begin
            col_cnt_next = col_cnt_reg + CW'(1);
            row_cnt_next = row_cnt_reg;
        end
        meta_next.col  = COORD_W'(col_cnt_reg - CW'(1));
        meta_next.row  = COORD_W'(row_cnt_reg - RW'(1));
        meta_next.last = at_row_end & at_last_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            v1_reg      <= 1'b0;
        end else begin
            v1_reg <= s_acc;
            if (s_acc) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
        end
        if (s_acc) begin
            p1_reg    <= s_gray_pixel;
            c1_reg    <= col_cnt_reg;
            emit1_reg <= (row_cnt_reg >= RW'(2)) && (col_cnt_reg >= CW'(2));
            meta1_reg <= meta_next;
        end
    end

    // ---------------------------------------------------------------- line stores
    // Read the column at acceptance; write it back in the next cycle. A column comes
    // round again no sooner than three pixels on, so the accesses never overlap.
    cgem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (c1_reg),
        .wdata (middle_rdata),
        .re    (s_acc),
        .raddr (col_cnt_reg),
        .rdata (upper_rdata)
    );

    cgem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (c1_reg),
        .wdata (p1_reg),
        .re    (s_acc),
        .raddr (col_cnt_reg),
        .rdata (middle_rdata)
    );

    // ---------------------------------------------------------------- window
    // Two older columns in registers, the newest from the line stores and the stage-1 pixel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (v1_reg) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= upper_rdata;
            win_reg[4] <= middle_rdata;
            win_reg[5] <= p1_reg;
        end
    end

    always_comb begin
        win[0] = win_reg[0];
        win[1] = win_reg[3];
        win[2] = upper_rdata;
        win[3] = win_reg[1];
        win[4] = win_reg[4];
        win[5] = middle_rdata;
        win[6] = win_reg[2];
        win[7] = win_reg[5];
        win[8] = p1_reg;
    end

    cgem_grad u_grad (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (v1_reg & emit1_reg),
        .win            (win),
        .in_meta        (meta1_reg),
        .auto_mode      (auto_mode_reg),
        .edge_threshold (edge_threshold_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // ---------------------------------------------------------------- result queue
    assign push = res_valid;
    assign pop  = m_valid & m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + NW'(push) - NW'(pop);
        end
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign m_valid      = fifo_cnt_reg != '0;
    assign m_edge_bit   = fifo_mem_reg[rd_ptr_reg].edge_bit;
    assign m_col_index  = fifo_mem_reg[rd_ptr_reg].col_index;
    assign m_row_index  = fifo_mem_reg[rd_ptr_reg].row_index;
    assign m_frame_done = fifo_mem_reg[rd_ptr_reg].frame_done;

`ifndef ASSERT_OFF
    // The credit check must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt_reg < NW'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= NW'(FIFO_DEPTH))
        else $error("result queue count out of range");

    // The line-store write-back never targets the column being read.
    a_no_ram_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && v1_reg) |-> (c1_reg != col_cnt_reg))
        else $error("line store read and write-back on the same column");

    // A result leaves the gradient stage only after an interior pixel went in.
    a_res_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> $past(v1_reg && emit1_reg))
        else $error("result without an interior pixel");
`endif

endmodule

`default_nettype wire

@@ sv/cgem_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module cgem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/cgem_grad.sv @@
// Compass gradient datapath: four difference sums, magnitude maximum and edge decision.
`default_nettype none

module cgem_grad
    import cgem_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire win_t      win,
    input  wire meta_t     in_meta,
    input  wire logic      auto_mode,
    input  wire logic [7:0] edge_threshold,
    output logic           res_valid,
    output result_t        res
);

    logic signed [GRAD_W-1:0] px [9];
    logic signed [GRAD_W-1:0] g_next [4];
    logic [SUM_W-1:0]         sum_next;

    logic signed [GRAD_W-1:0] g_reg [4];
    logic [SUM_W-1:0]         sum_reg;
    meta_t                    meta_reg;
    logic                     valid_reg;

    logic [MAG_W-1:0]    mag [4];
    logic [MAG_W-1:0]    max_lo;
    logic [MAG_W-1:0]    max_hi;
    logic [MAG_W-1:0]    best;
    logic [SCALED_W-1:0] scaled;
    logic                edge_hit;

    // Stage A: six-tap differences and neighbourhood sum
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            px[i] = signed'({{(GRAD_W-PIX_W){1'b0}}, win[i]});
        end
        // horizontal, vertical, then the two diagonals
        g_next[0] = -px[0] + px[2] - px[3] + px[5] - px[6] + px[8];
        g_next[1] = -px[0] + px[6] - px[1] + px[7] - px[2] + px[8];
        g_next[2] = -px[1] + px[3] - px[5] + px[7] - px[2] + px[6];
        g_next[3] = -px[1] + px[5] - px[3] + px[7] - px[0] + px[8];
        sum_next  = '0;
        for (int i = 0; i < 9; i++) begin
            sum_next = sum_next + SUM_W'(win[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        if (in_valid) begin
            g_reg    <= g_next;
            sum_reg  <= sum_next;
            meta_reg <= in_meta;
        end
    end

    // Stage B: largest magnitude, then compare
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag[k] = g_reg[k][GRAD_W-1] ? MAG_W'(-g_reg[k]) : MAG_W'(g_reg[k]);
        end
        max_lo = (mag[1] > mag[0]) ? mag[1] : mag[0];
        max_hi = (mag[3] > mag[2]) ? mag[3] : mag[2];
        best   = (max_hi > max_lo) ? max_hi : max_lo;
        scaled = (SCALED_W'(best) << 3) + (SCALED_W'(best) << 2);
        if (auto_mode) begin
            edge_hit = scaled > SCALED_W'(sum_reg);
        end else begin
            edge_hit = best > MAG_W'(edge_threshold);
        end
    end

    assign res_valid      = valid_reg;
    assign res.edge_bit   = edge_hit;
    assign res.col_index  = meta_reg.col;
    assign res.row_index  = meta_reg.row;
    assign res.frame_done = meta_reg.last;

endmodule

`default_nettype wire
